// File: src/dspe_pkg.sv
// ----------------------------------------------------------------------------
// dspe_pkg
// Shared constants, types and the microprogram of the dense shortest path
// engine.
// ----------------------------------------------------------------------------
package dspe_pkg;

   // Graph size and field widths
   localparam int NUM_VERTICES = 16;
   localparam int WEIGHT_BITS  = 8;
   localparam int VID_W        = 4;
   localparam int EDGE_W       = 8;
   localparam int DIST_W       = 16;
   localparam int MEM_DEPTH    = NUM_VERTICES * NUM_VERTICES;
   localparam int ADDR_W       = $clog2(MEM_DEPTH);
   localparam int ROUND_W      = $clog2(NUM_VERTICES);
   localparam int STEP_W       = 4;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   // Microprogram step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_INIT   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SELCLR = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SEL    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MARK   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_READ   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RELAX  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ROUND  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_OUTCLR = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DONE   = 4'd10;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_INIT,
      OP_SEL_CLR,
      OP_SEL,
      OP_MARK,
      OP_READ,
      OP_RELAX,
      OP_ROUND,
      OP_OUT_CLR,
      OP_EMIT
   } op_type;

   // Jump conditions: jump to target when true, else fall through
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_START,
      COND_NOT_VLAST,
      COND_UNREACH,
      COND_NOT_RLAST
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   // Microprogram ROM
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:   w = '{OP_NOP,     COND_NOT_START, STEP_IDLE};
         STEP_INIT:   w = '{OP_INIT,    COND_NEVER,     STEP_IDLE};
         STEP_SELCLR: w = '{OP_SEL_CLR, COND_NEVER,     STEP_IDLE};
         STEP_SEL:    w = '{OP_SEL,     COND_NOT_VLAST, STEP_SEL};
         STEP_MARK:   w = '{OP_MARK,    COND_UNREACH,   STEP_ROUND};
         STEP_READ:   w = '{OP_READ,    COND_NEVER,     STEP_IDLE};
         STEP_RELAX:  w = '{OP_RELAX,   COND_NOT_VLAST, STEP_READ};
         STEP_ROUND:  w = '{OP_ROUND,   COND_NOT_RLAST, STEP_SELCLR};
         STEP_OUTCLR: w = '{OP_OUT_CLR, COND_NEVER,     STEP_IDLE};
         STEP_EMIT:   w = '{OP_EMIT,    COND_NOT_VLAST, STEP_EMIT};
         STEP_DONE:   w = '{OP_NOP,     COND_ALWAYS,    STEP_IDLE};
         default:     w = '{OP_NOP,     COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: src/dense_shortest_path_engine_unit.sv
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_unit
// Single-source shortest paths over a dense weighted graph held in an
// adjacency-matrix store, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ---------------------------------------
//  request   start & !busy           req_cmd, req_row_vertex, req_col_vertex,
//                                    req_edge_weight, req_source_vertex
//  response  rsp_valid (one cycle)   rsp_vertex_id, rsp_path_length,
//                                    rsp_reachable, rsp_last
//
//  A load transaction writes the weight store in the accepting cycle; loads
//  stream one per cycle while the sequencer is idle. A run occupies the
//  sequencer through a select scan that checks one vertex a cycle and a
//  two-step relax loop over the single read port of the weight store; busy is
//  high throughout. Results follow one per cycle, each strobe registered from
//  its emit step.
//  Reset is synchronous: it clears the edge valid bits so the store reads as
//  empty at once. The receiver cannot stall results.
//
module dense_shortest_path_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic [dspe_pkg::VID_W-1:0]   req_row_vertex,
   input  logic [dspe_pkg::VID_W-1:0]   req_col_vertex,
   input  logic [dspe_pkg::EDGE_W-1:0]  req_edge_weight,
   input  logic [dspe_pkg::VID_W-1:0]   req_source_vertex,
   output logic                         rsp_valid,
   output logic [dspe_pkg::VID_W-1:0]   rsp_vertex_id,
   output logic [dspe_pkg::DIST_W-1:0]  rsp_path_length,
   output logic                         rsp_reachable,
   output logic                         rsp_last
);
   import dspe_pkg::*;

   // Sequencer
   logic [STEP_W-1:0]      step_ff, step_in;
   ctrl_word_type          cw;

   // Weight store and its valid bits
   logic [WEIGHT_BITS-1:0] wmem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]   wvld_ff;
   logic [WEIGHT_BITS-1:0] rd_ff;
   logic                   rd_vld_ff;

   // Per-vertex state
   logic [DIST_W-1:0]       dist_ff  [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] reach_ff;
   logic [NUM_VERTICES-1:0] visit_ff;

   // Working registers
   logic [VID_W-1:0]   v_ff;
   logic [VID_W-1:0]   pick_ff;
   logic [VID_W-1:0]   u_ff;
   logic [DIST_W:0]    best_ff;
   logic [ROUND_W-1:0] round_ff;
   logic [VID_W-1:0]   src_ff;

   logic               accept;
   logic               load_ok;
   logic [ADDR_W-1:0]  load_addr;
   logic [ADDR_W-1:0]  read_addr;
   logic               v_last;
   logic               r_last;
   logic               jump;
   logic [DIST_W:0]    key;
   logic [WEIGHT_BITS-1:0] w_eff;
   logic [DIST_W:0]    sum;
   logic [DIST_W-1:0]  sum_sat;

   assign busy      = (step_ff != STEP_IDLE);
   assign accept    = start && !busy;
   assign cw        = ucode_rom(step_ff);
   assign load_ok   = (int'(req_row_vertex) < NUM_VERTICES) &&
                      (int'(req_col_vertex) < NUM_VERTICES);
   assign load_addr = ADDR_W'(int'(req_row_vertex) * NUM_VERTICES + int'(req_col_vertex));
   assign read_addr = ADDR_W'(int'(u_ff) * NUM_VERTICES + int'(v_ff));
   assign v_last    = (v_ff == VID_W'(NUM_VERTICES - 1));
   assign r_last    = (round_ff == ROUND_W'(NUM_VERTICES - 2));

   // Form the select key: unreached vertices sit above every distance
   assign key = reach_ff[v_ff] ? {1'b0, dist_ff[v_ff]} : {1'b1, {DIST_W{1'b0}}};

   // Form the saturated relax sum
   assign w_eff   = rd_vld_ff ? rd_ff : '0;
   assign sum     = {1'b0, best_ff[DIST_W-1:0]} + (DIST_W+1)'(w_eff);
   assign sum_sat = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

   // Resolve the jump condition
   always_comb begin
      case (cw.cond)
         COND_NEVER:     jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NOT_START: jump = !(accept && (req_cmd == CMD_RUN));
         COND_NOT_VLAST: jump = !v_last;
         COND_UNREACH:   jump = best_ff[DIST_W];
         COND_NOT_RLAST: jump = !r_last;
         default:        jump = 1'b1;
      endcase
      step_in = jump ? cw.target : step_ff + STEP_W'(1);
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Write edge weights on load transactions
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_LOAD) && load_ok) begin
         wmem[load_addr] <= req_edge_weight[WEIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff <= '0;
      end else if (accept && (req_cmd == CMD_LOAD) && load_ok) begin
         wvld_ff[load_addr] <= 1'b1;
      end
   end

   // Read the weight store through a registered port
   always_ff @(posedge clock) begin
      if (cw.op == OP_READ) begin
         rd_ff     <= wmem[read_addr];
         rd_vld_ff <= wvld_ff[read_addr];
      end
   end

   // Capture the source on a run transaction
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_RUN)) begin
         src_ff <= req_source_vertex;
      end
   end

   // Datapath driven by the control word
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff  <= '0;
         visit_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (cw.op == OP_EMIT);
         case (cw.op)
            OP_INIT: begin
               for (int i = 0; i < NUM_VERTICES; i++) begin
                  dist_ff[i]  <= '0;
                  reach_ff[i] <= (int'(src_ff) == i);
                  visit_ff[i] <= 1'b0;
               end
               round_ff <= '0;
            end
            OP_SEL_CLR: begin
               best_ff <= {1'b1, {DIST_W{1'b0}}};
               pick_ff <= '0;
               v_ff    <= '0;
            end
            OP_SEL: begin
               // keep the later vertex on a tie
               if (!visit_ff[v_ff] && (key <= best_ff)) begin
                  best_ff <= key;
                  pick_ff <= v_ff;
               end
               v_ff <= v_ff + VID_W'(1);
            end
            OP_MARK: begin
               visit_ff[pick_ff] <= 1'b1;
               u_ff              <= pick_ff;
               v_ff              <= '0;
            end
            OP_RELAX: begin
               if (!visit_ff[v_ff] && (w_eff != '0) &&
                   (!reach_ff[v_ff] || (sum_sat < dist_ff[v_ff]))) begin
                  dist_ff[v_ff]  <= sum_sat;
                  reach_ff[v_ff] <= 1'b1;
               end
               v_ff <= v_ff + VID_W'(1);
            end
            OP_ROUND: begin
               round_ff <= round_ff + ROUND_W'(1);
            end
            OP_OUT_CLR: begin
               v_ff <= '0;
            end
            OP_EMIT: begin
               rsp_vertex_id   <= v_ff;
               rsp_path_length <= reach_ff[v_ff] ? dist_ff[v_ff] : '0;
               rsp_reachable   <= reach_ff[v_ff];
               rsp_last        <= v_last;
               v_ff            <= v_ff + VID_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

endmodule
